FILE: hdl/assert_macros.svh
// Assertion helpers shared by the RTL; every user has clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/udp_dd_pkg.sv
`timescale 1ns / 1ps

package udp_dd_pkg;

    localparam logic [15:0] FRAME_TYPE_IP4  = 16'h0800;
    localparam logic [7:0]  PROTO_NUM_UDP   = 8'd17;
    localparam logic [3:0]  HDR_WORDS_MASK  = 4'hF;
    localparam int unsigned HDR_WORD_BYTES  = 4;
    localparam int unsigned ETH_HDR_BYTES   = 14;
    localparam int unsigned UDP_HDR_BYTES   = 8;

    localparam logic [1:0] OP_PACKET   = 2'd0;
    localparam logic [1:0] OP_ADD      = 2'd1;
    localparam logic [1:0] OP_REMOVE   = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    localparam logic [2:0] ACT_DISPATCH  = 3'd0;
    localparam logic [2:0] ACT_TO_SENDER = 3'd1;
    localparam logic [2:0] ACT_NOT_IPV4  = 3'd2;
    localparam logic [2:0] ACT_NOT_UDP   = 3'd3;
    localparam logic [2:0] ACT_ADDED     = 3'd4;
    localparam logic [2:0] ACT_FULL      = 3'd5;
    localparam logic [2:0] ACT_REMOVED   = 3'd6;
    localparam logic [2:0] ACT_ABSENT    = 3'd7;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] frame_type;
        logic [7:0]  ip_protocol;
        logic [3:0]  header_words;
        logic [15:0] ip_total_length;
        logic [31:0] source_address;
        logic [15:0] source_port;
        logic [31:0] dest_address;
        logic [15:0] dest_port;
        logic [15:0] entry_handle;
        logic [31:0] bind_address;
        logic [15:0] bind_port;
    } request_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [3:0]  slot;
        logic [15:0] dispatch_handle;
        logic [31:0] reply_address;
        logic [15:0] reply_port;
        logic [6:0]  payload_offset;
        logic [15:0] payload_length;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [15:0] handle;
        logic [31:0] address;
        logic [15:0] port;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_FINISH,
        ST_REMOVE_WR
    } ctrl_state_t;

    typedef struct packed {
        logic       load;
        logic       idx_init;
        logic       idx_dec;
        logic       rd;
        logic       cap_last;
        logic       pend_load;
        logic       wr_add;
        logic       wr_remove;
        logic       emit;
        logic [2:0] act;
        logic       last;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic       is_ipv4;
        logic       is_udp;
        logic       full;
        logic       count_zero;
        logic       match;
        logic       idx_zero;
        logic       pend_valid;
    } dp_status_t;

endpackage

FILE: hdl/udp_dd_ctrl.sv
`timescale 1ns / 1ps

module udp_dd_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  udp_dd_pkg::dp_status_t status,
    output udp_dd_pkg::dp_cmd_t    cmd
);

    `include "assert_macros.svh"

    udp_dd_pkg::ctrl_state_t state_reg;
    udp_dd_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= udp_dd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            udp_dd_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = udp_dd_pkg::ST_DECODE;
                end
            end
            udp_dd_pkg::ST_DECODE:
            begin
                state_next = udp_dd_pkg::ST_IDLE;
                if (status.opcode == udp_dd_pkg::OP_PACKET && status.is_ipv4
                    && status.is_udp && !status.count_zero)
                begin
                    state_next = udp_dd_pkg::ST_SCAN_RD;
                end
                else if (status.opcode == udp_dd_pkg::OP_REMOVE && !status.count_zero)
                begin
                    state_next = udp_dd_pkg::ST_SCAN_RD;
                end
            end
            udp_dd_pkg::ST_SCAN_RD:
            begin
                state_next = udp_dd_pkg::ST_SCAN_CMP;
            end
            udp_dd_pkg::ST_SCAN_CMP:
            begin
                if (status.opcode == udp_dd_pkg::OP_REMOVE)
                begin
                    if (status.match)
                    begin
                        state_next = udp_dd_pkg::ST_REMOVE_WR;
                    end
                    else if (status.idx_zero)
                    begin
                        state_next = udp_dd_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = udp_dd_pkg::ST_SCAN_RD;
                    end
                end
                else
                begin
                    state_next = status.idx_zero ? udp_dd_pkg::ST_FINISH
                                                 : udp_dd_pkg::ST_SCAN_RD;
                end
            end
            udp_dd_pkg::ST_FINISH:
            begin
                state_next = udp_dd_pkg::ST_IDLE;
            end
            udp_dd_pkg::ST_REMOVE_WR:
            begin
                state_next = udp_dd_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = udp_dd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != udp_dd_pkg::ST_IDLE);
        unique case (state_reg)
            udp_dd_pkg::ST_IDLE:
            begin
                cmd.load = start;
            end
            udp_dd_pkg::ST_DECODE:
            begin
                unique case (status.opcode)
                    udp_dd_pkg::OP_PACKET:
                    begin
                        if (!status.is_ipv4)
                        begin
                            cmd.emit = 1'b1;
                            cmd.act  = udp_dd_pkg::ACT_NOT_IPV4;
                            cmd.last = 1'b1;
                        end
                        else if (!status.is_udp)
                        begin
                            cmd.emit = 1'b1;
                            cmd.act  = udp_dd_pkg::ACT_NOT_UDP;
                            cmd.last = 1'b1;
                        end
                        else if (status.count_zero)
                        begin
                            cmd.emit = 1'b1;
                            cmd.act  = udp_dd_pkg::ACT_TO_SENDER;
                            cmd.last = 1'b1;
                        end
                        else
                        begin
                            cmd.idx_init = 1'b1;
                        end
                    end
                    udp_dd_pkg::OP_ADD:
                    begin
                        cmd.emit   = 1'b1;
                        cmd.last   = 1'b1;
                        cmd.act    = status.full ? udp_dd_pkg::ACT_FULL
                                                 : udp_dd_pkg::ACT_ADDED;
                        cmd.wr_add = !status.full;
                    end
                    udp_dd_pkg::OP_REMOVE:
                    begin
                        if (status.count_zero)
                        begin
                            cmd.emit = 1'b1;
                            cmd.act  = udp_dd_pkg::ACT_ABSENT;
                            cmd.last = 1'b1;
                        end
                        else
                        begin
                            cmd.idx_init = 1'b1;
                        end
                    end
                    udp_dd_pkg::OP_RESERVED:
                    begin
                        cmd.emit = 1'b0;
                    end
                    default:
                    begin
                        cmd.emit = 1'b0;
                    end
                endcase
            end
            udp_dd_pkg::ST_SCAN_RD:
            begin
                cmd.rd = 1'b1;
            end
            udp_dd_pkg::ST_SCAN_CMP:
            begin
                cmd.cap_last = 1'b1;
                if (status.opcode == udp_dd_pkg::OP_REMOVE)
                begin
                    if (!status.match && status.idx_zero)
                    begin
                        cmd.emit = 1'b1;
                        cmd.act  = udp_dd_pkg::ACT_ABSENT;
                        cmd.last = 1'b1;
                    end
                    cmd.idx_dec = !status.match && !status.idx_zero;
                end
                else
                begin
                    // a new match releases the one held back, which is then not the last
                    cmd.pend_load = status.match;
                    cmd.emit      = status.match && status.pend_valid;
                    cmd.act       = udp_dd_pkg::ACT_DISPATCH;
                    cmd.idx_dec   = !status.idx_zero;
                end
            end
            udp_dd_pkg::ST_FINISH:
            begin
                cmd.emit = 1'b1;
                cmd.last = 1'b1;
                cmd.act  = status.pend_valid ? udp_dd_pkg::ACT_DISPATCH
                                             : udp_dd_pkg::ACT_TO_SENDER;
            end
            udp_dd_pkg::ST_REMOVE_WR:
            begin
                cmd.wr_remove = 1'b1;
                cmd.emit      = 1'b1;
                cmd.act       = udp_dd_pkg::ACT_REMOVED;
                cmd.last      = 1'b1;
            end
            default:
            begin
                cmd.emit = 1'b0;
            end
        endcase
    end

    `ASSERT_NEXT(a_accept_decodes, start && !busy, state_reg == udp_dd_pkg::ST_DECODE)
    `ASSERT_IMPL(a_write_needs_scan, cmd.wr_remove, $past(state_reg) == udp_dd_pkg::ST_SCAN_CMP)
    `ASSERT_NEXT(a_finish_idles, state_reg == udp_dd_pkg::ST_FINISH, !busy)

endmodule

FILE: hdl/udp_dd_datapath.sv
`timescale 1ns / 1ps

module udp_dd_datapath
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  udp_dd_pkg::request_t   request,
    input  udp_dd_pkg::dp_cmd_t    cmd,
    output udp_dd_pkg::dp_status_t status,
    output udp_dd_pkg::result_t    result,
    output logic                   result_strobe
);

    `include "assert_macros.svh"

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    udp_dd_pkg::entry_t mem [TABLE_DEPTH];

    udp_dd_pkg::request_t request_reg;
    udp_dd_pkg::entry_t   rd_data_reg;
    udp_dd_pkg::entry_t   last_entry_reg;
    udp_dd_pkg::result_t  result_reg;
    udp_dd_pkg::result_t  result_next;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic [CW-1:0]        count_m1;
    logic [IW-1:0]        idx_reg;
    logic [IW-1:0]        idx_next;
    logic                 pend_valid_reg;
    logic [3:0]           pend_slot_reg;
    logic [15:0]          pend_handle_reg;
    logic                 strobe_reg;

    logic                 wr_en;
    logic [IW-1:0]        wr_addr;
    udp_dd_pkg::entry_t   wr_data;
    logic [IW+3:0]        idx_wide;
    logic [IW+3:0]        cnt_wide;
    logic [3:0]           hw;
    logic [6:0]           ip_hdr;
    logic [6:0]           overhead;
    logic [6:0]           offset;
    logic [15:0]          length;

    assign count_m1 = count_reg - CW'(1);
    assign idx_wide = {4'b0000, idx_reg};
    assign cnt_wide = {4'b0000, count_reg[IW-1:0]};

    assign hw       = request_reg.header_words & udp_dd_pkg::HDR_WORDS_MASK;
    assign ip_hdr   = 7'(7'(hw) * 7'(udp_dd_pkg::HDR_WORD_BYTES));
    assign overhead = ip_hdr + 7'(udp_dd_pkg::UDP_HDR_BYTES);
    assign offset   = overhead + 7'(udp_dd_pkg::ETH_HDR_BYTES);
    assign length   = (request_reg.ip_total_length > {9'b0, overhead})
                    ? request_reg.ip_total_length - {9'b0, overhead} : 16'd0;

    always_comb
    begin
        wr_en   = cmd.wr_add | cmd.wr_remove;
        wr_addr = cmd.wr_add ? count_reg[IW-1:0] : idx_reg;
        wr_data = last_entry_reg;
        if (cmd.wr_add)
        begin
            wr_data.handle  = request_reg.entry_handle;
            wr_data.address = request_reg.bind_address;
            wr_data.port    = request_reg.bind_port;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.wr_add)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.wr_remove)
        begin
            count_next = count_m1;
        end
        idx_next = idx_reg;
        if (cmd.idx_init)
        begin
            idx_next = count_m1[IW-1:0];
        end
        else if (cmd.idx_dec)
        begin
            idx_next = idx_reg - IW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            strobe_reg <= cmd.emit;
            if (cmd.load)
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (cmd.pend_load)
            begin
                pend_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.load)
        begin
            request_reg <= request;
        end
        if (cmd.pend_load)
        begin
            pend_slot_reg   <= idx_wide[3:0];
            pend_handle_reg <= rd_data_reg.handle;
        end
        // the first entry read on a remove is the top one, kept to fill the hole
        if (cmd.cap_last && idx_reg == count_m1[IW-1:0])
        begin
            last_entry_reg <= rd_data_reg;
        end
        if (cmd.emit)
        begin
            result_reg <= result_next;
        end
    end

    always_comb
    begin
        result_next        = '0;
        result_next.action = cmd.act;
        result_next.last   = cmd.last;
        case (cmd.act)
            udp_dd_pkg::ACT_DISPATCH:
            begin
                result_next.slot            = pend_slot_reg;
                result_next.dispatch_handle = pend_handle_reg;
                result_next.reply_address   = request_reg.source_address;
                result_next.reply_port      = request_reg.source_port;
                result_next.payload_offset  = offset;
                result_next.payload_length  = length;
            end
            udp_dd_pkg::ACT_TO_SENDER:
            begin
                result_next.reply_address  = request_reg.source_address;
                result_next.reply_port     = request_reg.source_port;
                result_next.payload_offset = offset;
                result_next.payload_length = length;
            end
            udp_dd_pkg::ACT_ADDED:
            begin
                result_next.slot = cnt_wide[3:0];
            end
            udp_dd_pkg::ACT_REMOVED:
            begin
                result_next.slot = idx_wide[3:0];
            end
            default:
            begin
                result_next.slot = 4'd0;
            end
        endcase
    end

    always_comb
    begin
        status            = '0;
        status.opcode     = request_reg.opcode;
        status.is_ipv4    = (request_reg.frame_type == udp_dd_pkg::FRAME_TYPE_IP4);
        status.is_udp     = (request_reg.ip_protocol == udp_dd_pkg::PROTO_NUM_UDP);
        status.full       = (count_reg == CW'(TABLE_DEPTH));
        status.count_zero = (count_reg == '0);
        status.idx_zero   = (idx_reg == '0);
        status.pend_valid = pend_valid_reg;
        if (request_reg.opcode == udp_dd_pkg::OP_REMOVE)
        begin
            status.match = (rd_data_reg.handle == request_reg.entry_handle);
        end
        else
        begin
            status.match = (rd_data_reg.address == request_reg.dest_address)
                        && (rd_data_reg.port == request_reg.dest_port);
        end
    end

    assign result        = result_reg;
    assign result_strobe = strobe_reg;

    `ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(TABLE_DEPTH))
    `ASSERT_IMPL(a_single_last, strobe_reg && result_reg.action != udp_dd_pkg::ACT_DISPATCH, result_reg.last)
    `ASSERT_NEXT(a_remove_shrinks, cmd.wr_remove, count_reg == $past(count_m1))

endmodule

FILE: hdl/udp_dd_top.sv
// UDP destination demultiplexer. Drive a transaction on request with start while busy is
// low; an add appends an endpoint, a remove deletes one by handle (the top entry fills its
// slot), and a UDP header gives one dispatch result per matching endpoint, highest slot
// first, or a single to-sender result when none match. Results come out on result with a
// one-cycle result_strobe, the final one of a transaction flagged by last; the receiver
// cannot stall, so it must take every strobe. The table sits in a memory with separate read
// and write addresses, each entry read in one state and compared in the next. On an add, a
// non-UDP header or an empty table busy covers only decode; a UDP header scans every entry,
// a remove down to the matching handle. Each result appears the cycle after it is formed.
`timescale 1ns / 1ps

module udp_destination_demux_top
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  udp_dd_pkg::request_t request,
    output udp_dd_pkg::result_t  result,
    output logic                 result_strobe
);

    udp_dd_pkg::dp_cmd_t    cmd;
    udp_dd_pkg::dp_status_t status;

    udp_dd_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    udp_dd_datapath
    #(
        .TABLE_DEPTH (TABLE_DEPTH)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .request       (request),
        .cmd           (cmd),
        .status        (status),
        .result        (result),
        .result_strobe (result_strobe)
    );

endmodule
